// ===== rtl/core/mrf_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the request framer.
`default_nettype none

package mrf_pkg;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_register;
    logic [15:0] register_count;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       rejected;
  } res_t;

  // A request after classification by the front part.
  typedef struct packed {
    req_t req;
    logic refused;
  } job_t;

  // Status of the request queue as seen by the front and back parts.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0]  BROADCAST_ADDR = 8'h00;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Byte positions within a frame, in transmit order.
  localparam logic [2:0] POS_ADDR     = 3'd0;
  localparam logic [2:0] POS_FUNC     = 3'd1;
  localparam logic [2:0] POS_START_HI = 3'd2;
  localparam logic [2:0] POS_START_LO = 3'd3;
  localparam logic [2:0] POS_COUNT_HI = 3'd4;
  localparam logic [2:0] POS_COUNT_LO = 3'd5;
  localparam logic [2:0] POS_CRC_LO   = 3'd6;
  localparam logic [2:0] POS_CRC_HI   = 3'd7;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mrf_front.sv =====
// Front part: accepts requests, flags broadcast addresses and hands them to the queue.
`default_nettype none

module mrf_front
  import mrf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire req_t      request,
  input  wire q_status_t q_status,
  output logic           q_write,
  output job_t           q_data
);

  logic hold_valid;
  logic hold_valid_next;
  job_t hold;
  logic accept;

  assign full    = hold_valid && q_status.full;
  assign accept  = push && !full;
  assign q_write = hold_valid && !q_status.full;
  assign q_data  = hold;

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (q_write) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.req     <= request;
      hold.refused <= (request.slave_address == BROADCAST_ADDR);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mrf_queue.sv =====
// Short request queue that decouples the front part from the byte sequencer.
`default_nettype none

module mrf_queue
  import mrf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic write,
  input  wire job_t wdata,
  input  wire logic read,
  output job_t      rdata,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             do_write;
  logic             do_read;

  assign status.empty = (count == '0);
  assign status.full  = (count == FULL_CNT);
  assign do_write     = write && !status.full;
  assign do_read      = read && !status.empty;
  assign rdata        = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_write && !do_read) begin
      count_next = count + 1'b1;
    end else if (do_read && !do_write) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_write) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_read) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mrf_back.sv =====
// Back part: walks each queued request out as frame bytes and builds the CRC on the way.
`default_nettype none

module mrf_back
  import mrf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire q_status_t q_status,
  input  wire job_t      q_head,
  output logic           q_read,
  output logic           empty,
  input  wire logic      pop,
  output res_t           result
);

  logic        busy;
  logic        busy_next;
  logic [2:0]  pos;
  logic [2:0]  pos_next;
  logic [15:0] crc;
  logic [15:0] crc_next;
  req_t        job;
  logic        out_valid;
  logic        out_valid_next;
  res_t        res_next;
  logic        advance;
  logic [7:0]  data_byte;

  // The output register moves whenever it is empty or being taken.
  assign advance = !out_valid || pop;
  assign q_read  = advance && !busy && !q_status.empty;
  assign empty   = !out_valid;

  always_comb begin
    unique case (pos)
      POS_ADDR:     data_byte = job.slave_address;
      POS_FUNC:     data_byte = job.function_code;
      POS_START_HI: data_byte = job.start_register[15:8];
      POS_START_LO: data_byte = job.start_register[7:0];
      POS_COUNT_HI: data_byte = job.register_count[15:8];
      POS_COUNT_LO: data_byte = job.register_count[7:0];
      POS_CRC_LO:   data_byte = crc[7:0];
      POS_CRC_HI:   data_byte = crc[15:8];
    endcase
  end

  always_comb begin
    busy_next      = busy;
    pos_next       = pos;
    crc_next       = crc;
    out_valid_next = out_valid && !pop;
    res_next       = result;
    if (advance) begin
      if (busy) begin
        out_valid_next      = 1'b1;
        res_next.frame_byte = data_byte;
        res_next.last_byte  = (pos == POS_CRC_HI);
        res_next.rejected   = 1'b0;
        pos_next            = pos + 1'b1;
        if (pos < POS_CRC_LO) begin
          crc_next = crc16_byte(crc, data_byte);
        end
        if (pos == POS_CRC_HI) begin
          busy_next = 1'b0;
        end
      end else if (!q_status.empty) begin
        // The address byte leaves straight from the queue head.
        out_valid_next = 1'b1;
        if (q_head.refused) begin
          res_next.frame_byte = 8'h00;
          res_next.last_byte  = 1'b1;
          res_next.rejected   = 1'b1;
        end else begin
          res_next.frame_byte = q_head.req.slave_address;
          res_next.last_byte  = 1'b0;
          res_next.rejected   = 1'b0;
          busy_next           = 1'b1;
          pos_next            = POS_FUNC;
          crc_next            = crc16_byte(CRC_INIT, q_head.req.slave_address);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      pos       <= POS_ADDR;
    end else begin
      busy      <= busy_next;
      out_valid <= out_valid_next;
      pos       <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    crc    <= crc_next;
    result <= res_next;
    if (q_read) begin
      job <= q_head.req;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/modbus_rtu_request_framer_core.sv =====
// Top level of the Modbus RTU request framer: front, request queue and byte sequencer.
//
//   channel   direction  handshake          payload
//   request   in         push / full        req_t: address, function, start, count
//   result    out        pop / empty        res_t: frame byte, last flag, rejected flag
//
// A request becomes eight result bytes, one per cycle from the output register
// while pop is held high; a broadcast request gives one rejected result.
// The first byte passes the front hold register, the queue and the output register.
// Reset clears the front hold flag, the queue pointers and the sequencer; nothing is swept.
// A low pop holds the current result; the queue then fills and full rises.
`default_nettype none

module modbus_rtu_request_framer_core
  import mrf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire req_t request,
  output logic      empty,
  input  wire logic pop,
  output res_t      result
);

  q_status_t q_status;
  logic      q_write;
  logic      q_read;
  job_t      q_wdata;
  job_t      q_head;

  mrf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .q_status (q_status),
    .q_write  (q_write),
    .q_data   (q_wdata)
  );

  mrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .write  (q_write),
    .wdata  (q_wdata),
    .read   (q_read),
    .rdata  (q_head),
    .status (q_status)
  );

  mrf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_head   (q_head),
    .q_read   (q_read),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

// ===== tb/sv/modbus_rtu_request_framer_core_tb.sv =====
// Self-checking testbench for the Modbus RTU request framer core.
`timescale 1ns / 1ps

module modbus_rtu_request_framer_core_tb
  import mrf_pkg::*;
;

  localparam int          FRAME_LEN    = 8;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          TAIL_CYCLES  = 16;
  localparam int          PRINT_CAP    = 100;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam res_t        NONE_RES     = '0;

  typedef struct packed {
    req_t req;
    logic typed;
    res_t res;
  } table_row_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  req_t request;
  logic empty;
  logic pop;
  res_t result;

  res_t        frame_due_q[$];
  table_row_t  stim_table[$];
  int          mismatch_cnt;
  int          result_idx;
  int unsigned cycle_cnt;
  bit          req_taken;
  bit          cur_has_typed;
  res_t        cur_typed;
  bit          rx_hold_req;
  bit          rx_drain;

  modbus_rtu_request_framer_core u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [15:0] modbus_crc(input logic [47:0] body);
    logic [15:0] acc;
    acc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      acc = acc ^ {8'h00, body[47 - 8 * i -: 8]};
      for (int k = 0; k < 8; k++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  // Queues the bytes that one request must produce, in transmit order.
  function automatic void predict_frame(input req_t r);
    logic [47:0] body;
    logic [15:0] crc;
    logic [63:0] frame;
    res_t        item;
    if (r.slave_address == BROADCAST_ADDR) begin
      item.frame_byte = 8'h00;
      item.last_byte  = 1'b1;
      item.rejected   = 1'b1;
      frame_due_q.push_back(item);
      return;
    end
    body  = {r.slave_address, r.function_code, r.start_register, r.register_count};
    crc   = modbus_crc(body);
    frame = {body, crc[7:0], crc[15:8]};
    for (int k = 0; k < FRAME_LEN; k++) begin
      item.frame_byte = frame[63 - 8 * k -: 8];
      item.last_byte  = (k == FRAME_LEN - 1);
      item.rejected   = 1'b0;
      frame_due_q.push_back(item);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP) begin
      $display("MISMATCH @%0t result %0d: %s", $realtime, result_idx, msg);
    end
  endtask

  // Checks results first, then records newly accepted requests.
  always @(posedge clk) begin : monitor
    res_t due;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      req_taken = 1'b0;
      if (!rst) begin
        if (pop && !empty) begin
          if (frame_due_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", result));
          end else begin
            due = frame_due_q.pop_front();
            if (result.frame_byte !== due.frame_byte)
              report_mismatch($sformatf("frame_byte %h, want %h", result.frame_byte,
                                        due.frame_byte));
            if (result.last_byte !== due.last_byte)
              report_mismatch($sformatf("last_byte %b, want %b", result.last_byte,
                                        due.last_byte));
            if (result.rejected !== due.rejected)
              report_mismatch($sformatf("rejected %b, want %b", result.rejected,
                                        due.rejected));
          end
          result_idx++;
        end
        if (push && !full) begin
          req_taken = 1'b1;
          if (cur_has_typed) frame_due_q.push_back(cur_typed);
          else predict_frame(request);
        end
      end
    end
  end

  // Receiver: random stall modes, a long hold-off on demand, full rate at the end.
  initial begin : receiver
    int mode;
    int phase;
    int hold_left;
    int tick;
    mode      = 0;
    phase     = 0;
    hold_left = 0;
    tick      = 0;
    pop       = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (rx_hold_req) begin
        hold_left   = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (rx_drain) begin
        pop <= 1'b1;
      end else begin
        if (phase == 0) begin
          mode  = $urandom_range(0, 3);
          phase = $urandom_range(8, 40);
        end
        phase--;
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (tick % 4 != 3);
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic table_row(input logic [7:0] addr, input logic [7:0] func,
                           input logic [15:0] start, input logic [15:0] count,
                           input logic typed, input res_t res);
    table_row_t row;
    row.req.slave_address  = addr;
    row.req.function_code  = func;
    row.req.start_register = start;
    row.req.register_count = count;
    row.typed              = typed;
    row.res                = res;
    stim_table.push_back(row);
  endtask

  // Holds the request on the port until an edge takes it.
  task automatic offer_request(input req_t r, input logic typed, input res_t res);
    request       <= r;
    push          <= 1'b1;
    cur_has_typed  = typed;
    cur_typed      = res;
    @(negedge clk);
    while (!req_taken) @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_frames_done();
    push <= 1'b0;
    @(negedge clk);
    while (frame_due_q.size() != 0) @(negedge clk);
  endtask

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick             = $urandom_range(0, 19);
    r.slave_address  = 8'($urandom_range(1, 255));
    r.function_code  = 8'($urandom_range(0, 255));
    r.start_register = 16'($urandom_range(0, 65535));
    r.register_count = 16'($urandom_range(0, 65535));
    if (pick < 2) begin
      r.slave_address = BROADCAST_ADDR;
    end else if (pick < 4) begin
      r.slave_address  = $urandom_range(0, 1) ? 8'hFF : 8'h01;
      r.function_code  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      r.start_register = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      r.register_count = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    return r;
  endfunction

  // Random requests in bursts of random length with random gaps between them.
  task automatic send_random(input int n);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        pause_sender(gap);
      end
      offer_request(random_request(), 1'b0, NONE_RES);
      burst_left--;
    end
  endtask

  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    request       = '0;
    mismatch_cnt  = 0;
    result_idx    = 0;
    cycle_cnt     = 0;
    req_taken     = 1'b0;
    cur_has_typed = 1'b0;
    cur_typed     = NONE_RES;
    rx_hold_req   = 1'b0;
    rx_drain      = 1'b0;

    // Broadcast rows carry their single refused result typed in.
    table_row(8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, {8'h00, 1'b1, 1'b1});
    table_row(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, {8'h00, 1'b1, 1'b1});
    table_row(8'h01, 8'h03, 16'h0000, 16'h0001, 1'b0, NONE_RES);
    table_row(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NONE_RES);
    table_row(8'h01, 8'h00, 16'h0000, 16'h0000, 1'b0, NONE_RES);
    table_row(8'hFF, 8'h00, 16'h0000, 16'h0000, 1'b0, NONE_RES);
    table_row(8'h00, 8'h03, 16'h1234, 16'h0010, 1'b1, {8'h00, 1'b1, 1'b1});
    table_row(8'h80, 8'h80, 16'h8000, 16'h8000, 1'b0, NONE_RES);
    table_row(8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF, 1'b0, NONE_RES);
    table_row(8'h01, 8'h06, 16'h1234, 16'hABCD, 1'b0, NONE_RES);
    table_row(8'h11, 8'h01, 16'h0013, 16'h0025, 1'b0, NONE_RES);
    table_row(8'h11, 8'h02, 16'h00C4, 16'h0016, 1'b0, NONE_RES);
    table_row(8'h11, 8'h03, 16'h006B, 16'h0003, 1'b0, NONE_RES);
    table_row(8'h11, 8'h04, 16'h0008, 16'h0001, 1'b0, NONE_RES);
    table_row(8'h11, 8'h05, 16'h00AC, 16'hFF00, 1'b0, NONE_RES);
    table_row(8'h11, 8'h06, 16'h0001, 16'h0003, 1'b0, NONE_RES);
    table_row(8'h11, 8'h0F, 16'h0013, 16'h000A, 1'b0, NONE_RES);
    table_row(8'h11, 8'h10, 16'h0001, 16'h0002, 1'b0, NONE_RES);
    table_row(8'h00, 8'h10, 16'h00FF, 16'hFF00, 1'b1, {8'h00, 1'b1, 1'b1});
    table_row(8'h01, 8'hFF, 16'h00FF, 16'hFF00, 1'b0, NONE_RES);
    table_row(8'hFE, 8'h01, 16'hFF00, 16'h00FF, 1'b0, NONE_RES);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      offer_request(stim_table[i].req, stim_table[i].typed, stim_table[i].res);
      pause_sender($urandom_range(0, 2));
    end
    wait_frames_done();

    send_random(50);

    // Receiver holds off while requests keep coming, so the queue fills and full rises.
    rx_hold_req = 1'b1;
    for (int i = 0; i < 8; i++) begin
      offer_request(random_request(), 1'b0, NONE_RES);
    end
    wait_frames_done();

    send_random(50);

    rx_drain = 1'b1;
    wait_frames_done();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== modbus_rtu_request_framer_core.f =====
rtl/core/mrf_pkg.sv
rtl/core/mrf_front.sv
rtl/core/mrf_queue.sv
rtl/core/mrf_back.sv
rtl/core/modbus_rtu_request_framer_core.sv
tb/sv/modbus_rtu_request_framer_core_tb.sv
